// ===== hw/rtl/gceg_pkg.sv =====
`default_nettype none

package gceg_pkg;

  // fixed field widths
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned VTX_W    = 30;
  localparam int unsigned EDGE_W   = 33;
  localparam int unsigned SLOT_W   = 32;
  localparam int unsigned NDIR     = 6;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned IN_TW    = 8;
  localparam int unsigned OUT_TW   = 160;
  localparam int unsigned OUT_UW   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_DIM_Z = 2'd2;

  // neighbour directions in emission order
  typedef enum logic [2:0] {
    DIR_XN = 3'd0,
    DIR_XP = 3'd1,
    DIR_YN = 3'd2,
    DIR_YP = 3'd3,
    DIR_ZN = 3'd4,
    DIR_ZP = 3'd5
  } dir_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grid_csr_edge_generator_unit.sv =====
`default_nettype none
// grid csr edge generator
// walks a dim_x * dim_y * dim_z grid (x fastest) and emits its adjacency list
// in_*  : one item per vertex, in_tdata[0] = restart (walk begins again at vertex 0)
// out_* : one item per edge in order -x,+x,-y,+y,-z,+z; a vertex with no
//         neighbour gives a single item with has_edge low
// cfg_* : writes dim_x/dim_y/dim_z (index 0..2); values clamp to 1..DIM_MAX and
//         any dimension write sends the walk back to vertex 0
// the first result of a vertex passes the job register, then the output register
// a vertex yields 1 to 6 results; the job register hands one result per cycle
//   to the output register while the output is not stalled, and the next vertex
//   is taken in the cycle its last result is handed over
// a waiting result in the output register does not block acceptance of the
//   next vertex beyond that one job register
// in_tready is low for one cycle after a configuration write while the
//   x*y plane size is re-registered
// reset: dims go to 1, walk at vertex 0 with edge count 0, no result pending
// receiver stall: output item holds, emission stops, input is held off once
//   the job register is busy
module grid_csr_edge_generator_unit #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input item
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [gceg_pkg::IN_TW-1:0]    in_tdata,   // [0] restart, rest zero
  // result item
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [29:0] source_vertex, [59:30] neighbour_vertex, [92:60] edge_position,
  // [124:93] weight_slot, [157:125] prefix_end, [159:158] zero
  output logic [gceg_pkg::OUT_TW-1:0]        out_tdata,
  output logic                               out_tlast,  // last_of_vertex
  output logic [gceg_pkg::OUT_UW-1:0]        out_tuser,  // [0] has_edge, [1] last_of_grid
  // configuration write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [gceg_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [gceg_pkg::DIM_W-1:0]    cfg_data
);
  import gceg_pkg::*;

  // largest dimension the 11-bit register can hold under the clamp
  localparam logic [DIM_W-1:0] DIM_MAX =
    (MAX_DIM > 2047) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

  // configuration and walk state
  logic [DIM_W-1:0]   dim_x_r, dim_y_r, dim_z_r;
  logic [2*DIM_W-1:0] plane_r;
  logic               cfg_wait_r;
  logic [POS_W-1:0]   pos_x_r, pos_y_r, pos_z_r;
  logic [VTX_W-1:0]   vidx_r;
  logic [EDGE_W-1:0]  ecount_r;

  // job register: one vertex being broken into results
  logic               job_valid_r;
  logic [NDIR-1:0]    rem_r;
  logic               iso_r;
  logic [VTX_W-1:0]   src_r;
  logic [EDGE_W-1:0]  epos_r;
  logic [EDGE_W-1:0]  pend_r;
  logic               lg_r;

  // output register
  logic               out_valid_r;
  logic [VTX_W-1:0]   o_src_r, o_nb_r;
  logic [EDGE_W-1:0]  o_epos_r, o_pend_r;
  logic [SLOT_W-1:0]  o_slot_r;
  logic               o_has_r, o_lv_r, o_lg_r;

  logic cfg_fire, in_fire, emit, job_done, last_res;
  logic [DIM_W-1:0] cfg_clamped;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_data > DIM_MAX) begin
      cfg_clamped = DIM_MAX;
    end
  end

  // ---------------- vertex acceptance ----------------
  logic              restart;
  logic [POS_W-1:0]  px, py, pz;
  logic [VTX_W-1:0]  src_in;
  logic [EDGE_W-1:0] ec_in, pend_in;
  logic [NDIR-1:0]   flags;
  logic [2:0]        nedges;
  logic              lx, ly, lz, lg_in;

  assign restart = in_tdata[0];
  assign px      = restart ? '0 : pos_x_r;
  assign py      = restart ? '0 : pos_y_r;
  assign pz      = restart ? '0 : pos_z_r;
  assign src_in  = restart ? '0 : vidx_r;
  assign ec_in   = restart ? '0 : ecount_r;

  // a coordinate is at the far face when coord + 1 == dim
  assign lx = ({1'b0, px} + (POS_W+1)'(1)) == {1'b0, dim_x_r};
  assign ly = ({1'b0, py} + (POS_W+1)'(1)) == {1'b0, dim_y_r};
  assign lz = ({1'b0, pz} + (POS_W+1)'(1)) == {1'b0, dim_z_r};

  assign flags[DIR_XN] = (px != '0);
  assign flags[DIR_XP] = ({1'b0, px} + (POS_W+1)'(1)) < {1'b0, dim_x_r};
  assign flags[DIR_YN] = (py != '0);
  assign flags[DIR_YP] = ({1'b0, py} + (POS_W+1)'(1)) < {1'b0, dim_y_r};
  assign flags[DIR_ZN] = (pz != '0);
  assign flags[DIR_ZP] = ({1'b0, pz} + (POS_W+1)'(1)) < {1'b0, dim_z_r};

  assign nedges  = 3'($countones(flags));
  assign pend_in = ec_in + EDGE_W'(nedges);
  assign lg_in   = lx & ly & lz;

  // ---------------- result selection ----------------
  logic [NDIR-1:0]   pick;
  dir_t              dir;
  logic [SLOT_W-1:0] src32, off32, nb32, base32, slot32;
  logic [1:0]        axis;

  assign pick     = rem_r & (~rem_r + NDIR'(1));
  assign last_res = iso_r | ((rem_r & ~pick) == '0);
  assign emit     = job_valid_r & (~out_valid_r | out_tready);
  assign job_done = emit & last_res;
  assign in_tready = ~cfg_wait_r & (~job_valid_r | job_done);
  assign in_fire   = in_tvalid & in_tready;

  always_comb begin
    priority if (rem_r[DIR_XN]) dir = DIR_XN;
    else if (rem_r[DIR_XP])     dir = DIR_XP;
    else if (rem_r[DIR_YN])     dir = DIR_YN;
    else if (rem_r[DIR_YP])     dir = DIR_YP;
    else if (rem_r[DIR_ZN])     dir = DIR_ZN;
    else                        dir = DIR_ZP;
  end

  assign src32 = SLOT_W'(src_r);
  assign axis  = dir[2:1];

  always_comb begin
    unique case (dir)
      DIR_XN, DIR_XP: off32 = SLOT_W'(1);
      DIR_YN, DIR_YP: off32 = SLOT_W'(dim_x_r);
      DIR_ZN, DIR_ZP: off32 = SLOT_W'(plane_r);
      default:        off32 = '0;
    endcase
  end

  // negative direction: the neighbour is the lower vertex of the pair
  assign nb32   = dir[0] ? (src32 + off32) : (src32 - off32);
  assign base32 = dir[0] ? src32 : nb32;
  assign slot32 = (base32 << 1) + base32 + SLOT_W'(axis);

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r    <= DIM_W'(1);
      dim_y_r    <= DIM_W'(1);
      dim_z_r    <= DIM_W'(1);
      cfg_wait_r <= 1'b0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      pos_z_r    <= '0;
      vidx_r     <= '0;
      ecount_r   <= '0;
    end else begin
      cfg_wait_r <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_DIM_X: dim_x_r <= cfg_clamped;
          REG_DIM_Y: dim_y_r <= cfg_clamped;
          REG_DIM_Z: dim_z_r <= cfg_clamped;
          default: ;
        endcase
        if (cfg_index == REG_DIM_X || cfg_index == REG_DIM_Y ||
            cfg_index == REG_DIM_Z) begin
          pos_x_r  <= '0;
          pos_y_r  <= '0;
          pos_z_r  <= '0;
          vidx_r   <= '0;
          ecount_r <= '0;
        end
      end else if (in_fire) begin
        if (lg_in) begin
          // wrap to the start after the final vertex
          pos_x_r  <= '0;
          pos_y_r  <= '0;
          pos_z_r  <= '0;
          vidx_r   <= '0;
          ecount_r <= '0;
        end else begin
          ecount_r <= pend_in;
          vidx_r   <= src_in + VTX_W'(1);
          if (lx) begin
            pos_x_r <= '0;
            if (ly) begin
              pos_y_r <= '0;
              pos_z_r <= pz + POS_W'(1);
            end else begin
              pos_y_r <= py + POS_W'(1);
              pos_z_r <= pz;
            end
          end else begin
            pos_x_r <= px + POS_W'(1);
            pos_y_r <= py;
            pos_z_r <= pz;
          end
        end
      end
    end
  end

  // plane size, re-registered every cycle
  always_ff @(posedge clk) begin
    plane_r <= dim_x_r * dim_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (in_fire) begin
      job_valid_r <= 1'b1;
    end else if (job_done) begin
      job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rem_r  <= flags;
      iso_r  <= (flags == '0);
      src_r  <= src_in;
      epos_r <= ec_in;
      pend_r <= pend_in;
      lg_r   <= lg_in;
    end else if (emit) begin
      rem_r  <= rem_r & ~pick;
      epos_r <= epos_r + EDGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_src_r  <= src_r;
      o_pend_r <= pend_r;
      o_lg_r   <= lg_r;
      o_lv_r   <= last_res;
      o_has_r  <= ~iso_r;
      if (iso_r) begin
        o_nb_r   <= '0;
        o_epos_r <= '0;
        o_slot_r <= '0;
      end else begin
        o_nb_r   <= nb32[VTX_W-1:0];
        o_epos_r <= epos_r;
        o_slot_r <= slot32;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TW - 2*VTX_W - 2*EDGE_W - SLOT_W){1'b0}},
                       o_pend_r, o_slot_r, o_epos_r, o_nb_r, o_src_r};
  assign out_tlast  = o_lv_r;
  assign out_tuser  = {o_lg_r, o_has_r};

  // ---------------- assertions ----------------
  // an isolated-vertex result is always the last one of its vertex
  a_iso_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("isolated result without last_of_vertex");

  // the last edge of a vertex sits just before its prefix entry
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] && out_tlast) |-> (o_epos_r + EDGE_W'(1) == o_pend_r))
    else $error("prefix_end does not follow last edge position");

  // a dimension write puts the walk back at vertex zero
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && (cfg_index == REG_DIM_X || cfg_index == REG_DIM_Y ||
                  cfg_index == REG_DIM_Z)) |=> (vidx_r == '0 && ecount_r == '0))
    else $error("walk not cleared by configuration write");

endmodule

`default_nettype wire
